// File: hdl/tkx_pkg.sv
// ----------------------------------------------------------------------------
// tkx_pkg
// shared constants, types and helpers of the top-k extrema block
// ----------------------------------------------------------------------------
`default_nettype none

package tkx_pkg;

  // ranked list depth and stored coordinate width
  localparam int unsigned Entries   = 16;
  localparam int unsigned CoordBits = 16;

  // fixed field widths
  localparam int unsigned ValW      = 33;
  localparam int unsigned PortCoordW = 16;
  localparam int unsigned RankW     = 6;
  localparam int unsigned CntW      = 7;
  localparam int unsigned CfgIdxW   = 8;
  localparam int unsigned CfgDataW  = 7;

  // derived widths
  localparam int unsigned IdxW   = (Entries > 1) ? $clog2(Entries) : 1;
  localparam int unsigned CoordW = (CoordBits < PortCoordW) ? CoordBits : PortCoordW;

  // register indexes
  localparam logic [CfgIdxW-1:0] RegModeMin    = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] RegCountInUse = CfgIdxW'(1);

  // reset values of the registers
  localparam logic            ModeReset  = 1'b0;
  localparam logic [CntW-1:0] CountReset = CntW'(16);

  // seeds of the list per mode
  localparam logic signed [ValW-1:0] SeedMax = '0;
  localparam logic signed [ValW-1:0] SeedMin = 33'sh0_FFFF_FFFF;

  typedef enum logic [1:0] {
    StIdle = 2'b01,
    StRead = 2'b10
  } tkx_state_e;

  // controller to datapath
  typedef struct packed {
    logic            ins_en;
    logic            load;
    logic            last;
    logic            reseed;
    logic [IdxW-1:0] rd_idx;
  } tkx_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic [IdxW-1:0] last_idx;
  } tkx_status_t;

  // index of the worst entry in use, count clamped to 1..Entries
  function automatic logic [IdxW-1:0] last_index(input logic [CntW-1:0] c);
    logic [IdxW-1:0] r;
    if (c == '0) begin
      r = '0;
    end else if (c > CntW'(Entries)) begin
      r = IdxW'(Entries - 1);
    end else begin
      r = IdxW'(c - CntW'(1));
    end
    return r;
  endfunction

  function automatic logic signed [ValW-1:0] seed_of(input logic mode_min);
    return mode_min ? SeedMin : SeedMax;
  endfunction

endpackage

`default_nettype wire

// File: hdl/tkx_if.sv
// ----------------------------------------------------------------------------
// tkx channel interfaces
// pixel input, ranked result output and register write channels
// ----------------------------------------------------------------------------
`default_nettype none

interface tkx_pixel_if;
  logic                                valid;
  logic                                ready;
  logic signed [tkx_pkg::ValW-1:0]     pixel_value;
  logic [tkx_pkg::PortCoordW-1:0]      pixel_x;
  logic [tkx_pkg::PortCoordW-1:0]      pixel_y;
  logic                                frame_end;

  modport source (output valid, pixel_value, pixel_x, pixel_y, frame_end, input ready);
  modport sink   (input valid, pixel_value, pixel_x, pixel_y, frame_end, output ready);
endinterface

interface tkx_result_if;
  logic                                valid;
  logic                                ready;
  logic [tkx_pkg::RankW-1:0]           rank;
  logic [tkx_pkg::PortCoordW-1:0]      out_x;
  logic [tkx_pkg::PortCoordW-1:0]      out_y;
  logic signed [tkx_pkg::ValW-1:0]     out_value;
  logic                                last;

  modport source (output valid, rank, out_x, out_y, out_value, last, input ready);
  modport sink   (input valid, rank, out_x, out_y, out_value, last, output ready);
endinterface

interface tkx_cfg_if;
  logic                                valid;
  logic                                ready;
  logic [tkx_pkg::CfgIdxW-1:0]         index;
  logic [tkx_pkg::CfgDataW-1:0]        data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// File: hdl/tkx_ctrl.sv
// ----------------------------------------------------------------------------
// tkx_ctrl
// sequencer for pixel intake and ranked list readout
// ----------------------------------------------------------------------------
`default_nettype none

module tkx_ctrl (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  input  wire logic                in_frame_end_i,
  output logic                     in_ready_o,
  input  wire logic                out_ready_i,
  output logic                     out_valid_o,
  input  wire tkx_pkg::tkx_status_t status_i,
  output tkx_pkg::tkx_cmd_t        cmd_o
);

  localparam int unsigned IdxW = tkx_pkg::IdxW;

  tkx_pkg::tkx_state_e state_q, state_d;
  logic [IdxW-1:0]     k_q, k_d;
  logic                out_valid_q, out_valid_d;
  logic                in_acc;
  logic                out_free;

  assign in_ready_o = (state_q == tkx_pkg::StIdle);
  assign in_acc     = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;

  always_comb begin
    state_d       = state_q;
    k_d           = k_q;
    cmd_o.ins_en  = in_acc;
    cmd_o.load    = 1'b0;
    cmd_o.last    = 1'b0;
    cmd_o.reseed  = 1'b0;
    cmd_o.rd_idx  = k_q;
    unique case (state_q)
      tkx_pkg::StIdle: begin
        if (in_acc && in_frame_end_i) begin
          state_d = tkx_pkg::StRead;
          k_d     = '0;
        end
      end
      tkx_pkg::StRead: begin
        if (out_free) begin
          cmd_o.load = 1'b1;
          if (k_q == status_i.last_idx) begin
            cmd_o.last   = 1'b1;
            cmd_o.reseed = 1'b1;
            k_d          = '0;
            state_d      = tkx_pkg::StIdle;
          end else begin
            k_d = k_q + IdxW'(1);
          end
        end
      end
      default: begin
        state_d = tkx_pkg::StIdle;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= tkx_pkg::StIdle;
      k_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      k_q         <= k_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

`default_nettype wire

// File: hdl/tkx_datapath.sv
// ----------------------------------------------------------------------------
// tkx_datapath
// ranked entry cells with parallel compare and shift, registers, output stage
// ----------------------------------------------------------------------------
`default_nettype none

module tkx_datapath (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire tkx_pkg::tkx_cmd_t                   cmd_i,
  output tkx_pkg::tkx_status_t                     status_o,
  input  wire logic signed [tkx_pkg::ValW-1:0]     pixel_value_i,
  input  wire logic [tkx_pkg::PortCoordW-1:0]      pixel_x_i,
  input  wire logic [tkx_pkg::PortCoordW-1:0]      pixel_y_i,
  input  wire logic                                cfg_we_i,
  input  wire logic [tkx_pkg::CfgIdxW-1:0]         cfg_index_i,
  input  wire logic [tkx_pkg::CfgDataW-1:0]        cfg_data_i,
  output logic [tkx_pkg::RankW-1:0]                rank_o,
  output logic [tkx_pkg::PortCoordW-1:0]           out_x_o,
  output logic [tkx_pkg::PortCoordW-1:0]           out_y_o,
  output logic signed [tkx_pkg::ValW-1:0]          out_value_o,
  output logic                                     last_o
);

  localparam int unsigned Entries = tkx_pkg::Entries;
  localparam int unsigned IdxW    = tkx_pkg::IdxW;
  localparam int unsigned ValW    = tkx_pkg::ValW;
  localparam int unsigned CoordW  = tkx_pkg::CoordW;
  localparam int unsigned PCW     = tkx_pkg::PortCoordW;
  localparam int unsigned CntW    = tkx_pkg::CntW;
  localparam int unsigned RankW   = tkx_pkg::RankW;

  logic                   mode_q, mode_d;
  logic [CntW-1:0]        count_q, count_d;
  logic                   cfg_hit;
  logic                   seed_mode;

  logic signed [ValW-1:0] val_q [Entries];
  logic signed [ValW-1:0] val_d [Entries];
  logic [CoordW-1:0]      x_q   [Entries];
  logic [CoordW-1:0]      x_d   [Entries];
  logic [CoordW-1:0]      y_q   [Entries];
  logic [CoordW-1:0]      y_d   [Entries];

  logic [Entries-1:0]     beat;
  logic [Entries-1:0]     beat_prev;
  logic signed [ValW-1:0] val_prev [Entries];
  logic [CoordW-1:0]      x_prev   [Entries];
  logic [CoordW-1:0]      y_prev   [Entries];
  logic [IdxW-1:0]        last_idx;
  logic                   ins_ok;
  logic [CoordW-1:0]      px, py;

  assign last_idx          = tkx_pkg::last_index(count_q);
  assign status_o.last_idx = last_idx;
  assign px                = CoordW'(pixel_x_i);
  assign py                = CoordW'(pixel_y_i);

  // decoded register writes reseed with the mode in force after them
  always_comb begin
    mode_d  = mode_q;
    count_d = count_q;
    cfg_hit = 1'b0;
    if (cfg_we_i) begin
      unique case (cfg_index_i)
        tkx_pkg::RegModeMin: begin
          mode_d  = cfg_data_i[0];
          cfg_hit = 1'b1;
        end
        tkx_pkg::RegCountInUse: begin
          count_d = CntW'(cfg_data_i);
          cfg_hit = 1'b1;
        end
        default: begin
          cfg_hit = 1'b0;
        end
      endcase
    end
  end

  assign seed_mode = mode_d;

  // per-cell strict compare against the incoming pixel
  always_comb begin
    for (int i = 0; i < Entries; i++) begin
      beat[i] = mode_q ? (pixel_value_i < val_q[i]) : (pixel_value_i > val_q[i]);
    end
  end

  always_comb begin
    beat_prev[0] = 1'b0;
    val_prev[0]  = val_q[0];
    x_prev[0]    = x_q[0];
    y_prev[0]    = y_q[0];
    for (int i = 1; i < Entries; i++) begin
      beat_prev[i] = beat[i-1];
      val_prev[i]  = val_q[i-1];
      x_prev[i]    = x_q[i-1];
      y_prev[i]    = y_q[i-1];
    end
  end

  assign ins_ok = cmd_i.ins_en && beat[last_idx];

  always_comb begin
    for (int i = 0; i < Entries; i++) begin
      val_d[i] = val_q[i];
      x_d[i]   = x_q[i];
      y_d[i]   = y_q[i];
      if (cmd_i.reseed || cfg_hit) begin
        val_d[i] = tkx_pkg::seed_of(seed_mode);
        x_d[i]   = '0;
        y_d[i]   = '0;
      end else if (ins_ok && (IdxW'(i) <= last_idx)) begin
        if (beat[i] && !beat_prev[i]) begin
          // insertion point: first entry the pixel strictly beats
          val_d[i] = pixel_value_i;
          x_d[i]   = px;
          y_d[i]   = py;
        end else if (beat_prev[i]) begin
          val_d[i] = val_prev[i];
          x_d[i]   = x_prev[i];
          y_d[i]   = y_prev[i];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= tkx_pkg::ModeReset;
      count_q <= tkx_pkg::CountReset;
      for (int i = 0; i < Entries; i++) begin
        val_q[i] <= tkx_pkg::seed_of(tkx_pkg::ModeReset);
        x_q[i]   <= '0;
        y_q[i]   <= '0;
      end
    end else begin
      mode_q  <= mode_d;
      count_q <= count_d;
      for (int i = 0; i < Entries; i++) begin
        val_q[i] <= val_d[i];
        x_q[i]   <= x_d[i];
        y_q[i]   <= y_d[i];
      end
    end
  end

  // output stage
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      rank_o      <= RankW'(cmd_i.rd_idx);
      out_x_o     <= PCW'(x_q[cmd_i.rd_idx]);
      out_y_o     <= PCW'(y_q[cmd_i.rd_idx]);
      out_value_o <= val_q[cmd_i.rd_idx];
      last_o      <= cmd_i.last;
    end
  end

endmodule

`default_nettype wire

// File: hdl/top_k_extrema_with_position.sv
// ----------------------------------------------------------------------------
// top_k_extrema_with_position
// ranked list of the best pixels of a frame with their coordinates
// ----------------------------------------------------------------------------
// throughput: one pixel per cycle while idle, set by the compare-and-shift cells
// frame end: merged in its accept cycle; read state loads first result to output reg
// readout: count_in_use results clamped to 1..16, one per cycle while taken;
//   pixel input stalls until the last result is loaded into the output register
// reset: asynchronous, list seeded and registers set at once, no clearing pass
`default_nettype none

module top_k_extrema_with_position (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  tkx_pixel_if.sink    pix_i,
  tkx_result_if.source res_o,
  tkx_cfg_if.sink      cfg_i
);

  tkx_pkg::tkx_cmd_t    cmd;
  tkx_pkg::tkx_status_t status;
  logic                 cfg_we;

  // register writes are always taken
  assign cfg_i.ready = 1'b1;
  assign cfg_we      = cfg_i.valid && cfg_i.ready;

  // controller: intake while idle, then steps the readout index
  tkx_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (pix_i.valid),
    .in_frame_end_i (pix_i.frame_end),
    .in_ready_o     (pix_i.ready),
    .out_ready_i    (res_o.ready),
    .out_valid_o    (res_o.valid),
    .status_i       (status),
    .cmd_o          (cmd)
  );

  // datapath: ranked cells, registers and the output register
  tkx_datapath u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .status_o      (status),
    .pixel_value_i (pix_i.pixel_value),
    .pixel_x_i     (pix_i.pixel_x),
    .pixel_y_i     (pix_i.pixel_y),
    .cfg_we_i      (cfg_we),
    .cfg_index_i   (cfg_i.index),
    .cfg_data_i    (cfg_i.data),
    .rank_o        (res_o.rank),
    .out_x_o       (res_o.out_x),
    .out_y_o       (res_o.out_y),
    .out_value_o   (res_o.out_value),
    .last_o        (res_o.last)
  );

endmodule

`default_nettype wire

// File: hdl/tkx_checker.sv
// ----------------------------------------------------------------------------
// tkx_checker
// port-level checks of intake stall and readout sequencing
// ----------------------------------------------------------------------------
`default_nettype none

module tkx_checker (
  input wire logic                              clk_i,
  input wire logic                              rst_ni,
  input wire logic                              in_valid_i,
  input wire logic                              in_ready_i,
  input wire logic                              in_frame_end_i,
  input wire logic                              out_valid_i,
  input wire logic                              out_ready_i,
  input wire logic [tkx_pkg::RankW-1:0]         out_rank_i,
  input wire logic                              out_last_i
);

  localparam int unsigned RankW = tkx_pkg::RankW;

  // a stalled result holds its rank and last flag
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_rank_i) && $stable(out_last_i))
    else $error("stalled result changed");

  // intake stops once a frame end request is taken
  a_frame_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i && in_frame_end_i |=> !in_ready_i)
    else $error("pixel intake open during readout");

  // a readout still in progress keeps intake closed
  a_read_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_last_i |-> !in_ready_i)
    else $error("pixel intake open before last result");

  // readout runs without gaps in ascending rank
  a_rank_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_ready_i && !out_last_i |=>
      out_valid_i && (out_rank_i == RankW'($past(out_rank_i) + RankW'(1))))
    else $error("readout rank sequence broken");

endmodule

bind top_k_extrema_with_position tkx_checker u_tkx_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (pix_i.valid),
  .in_ready_i     (pix_i.ready),
  .in_frame_end_i (pix_i.frame_end),
  .out_valid_i    (res_o.valid),
  .out_ready_i    (res_o.ready),
  .out_rank_i     (res_o.rank),
  .out_last_i     (res_o.last)
);

`default_nettype wire

// File: dv/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the top-k extrema block: a shadow ranked list
// predicts every readout, directed frames hit seeds, ties, count limits and
// register side effects, then random raster frames run under back-pressure
// ----------------------------------------------------------------------------

module tb_top;

  // shared widths and register indexes of the block
  localparam int unsigned Entries    = tkx_pkg::Entries;
  localparam int unsigned CoordW     = tkx_pkg::CoordW;
  localparam int unsigned ValW       = tkx_pkg::ValW;
  localparam int unsigned PortCoordW = tkx_pkg::PortCoordW;
  localparam int unsigned RankW      = tkx_pkg::RankW;
  localparam int unsigned CntW       = tkx_pkg::CntW;
  localparam int unsigned CfgIdxW    = tkx_pkg::CfgIdxW;
  localparam int unsigned CfgDataW   = tkx_pkg::CfgDataW;
  localparam logic [CfgIdxW-1:0] RegModeMin    = tkx_pkg::RegModeMin;
  localparam logic [CfgIdxW-1:0] RegCountInUse = tkx_pkg::RegCountInUse;

  // run length guards
  localparam int unsigned CycleLimit   = 200000;
  localparam int unsigned DrainCycles  = 20;
  localparam int unsigned SettleCycles = 4;
  localparam int unsigned HoldLen      = 150;
  localparam int unsigned RandPixels   = 150;

  // register indexes the block does not decode
  localparam logic [CfgIdxW-1:0] RegUnusedLow  = CfgIdxW'(2);
  localparam logic [CfgIdxW-1:0] RegUnusedHigh = '1;

  // seeds of the shadow list and the coordinate mask
  localparam logic signed [ValW-1:0] FloorSeed = '0;
  localparam logic signed [ValW-1:0] CeilSeed  = 33'sh0_FFFF_FFFF;
  localparam logic [PortCoordW-1:0]  XyMask    = PortCoordW'((64'd1 << CoordW) - 64'd1);

  // extreme sample values
  localparam logic signed [ValW-1:0] ValTop    = 33'sh0_FFFF_FFFF;
  localparam logic signed [ValW-1:0] ValBottom = -33'sh0_8000_0000;

  typedef struct {
    logic [RankW-1:0]             rank;
    logic [PortCoordW-1:0]        x;
    logic [PortCoordW-1:0]        y;
    logic signed [ValW-1:0]       value;
    logic                         last;
  } ranked_entry_t;

  logic clk_i;
  logic rst_ni;

  tkx_pixel_if  pix ();
  tkx_result_if res ();
  tkx_cfg_if    cfg ();

  top_k_extrema_with_position u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .pix_i  (pix),
    .res_o  (res),
    .cfg_i  (cfg)
  );

  // shadow copy of the ranked list and the registers
  logic signed [ValW-1:0]  shadow_val [Entries];
  logic [PortCoordW-1:0]   shadow_x   [Entries];
  logic [PortCoordW-1:0]   shadow_y   [Entries];
  logic                    shadow_min_mode;
  logic [CntW-1:0]         shadow_count;

  // readout entries still owed by the block, oldest first
  ranked_entry_t readout_q [$];

  int unsigned err_cnt    = 0;
  int unsigned cycle_cnt  = 0;
  int unsigned pixels_out = 0;
  bit          calm       = 1'b0;   // no idling on either side while set
  int unsigned hold_token = 0;      // bumped to ask the receiver for a long hold-off
  int unsigned hold_seen  = 0;
  int unsigned hold_left  = 0;

  // ---------------------------------------------------------------------------
  // clock, timeout
  // ---------------------------------------------------------------------------
  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    while (cycle_cnt < CycleLimit) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("[FAIL] regression broken");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // shadow list
  // ---------------------------------------------------------------------------
  // count 0 behaves as one entry, anything past the depth as the full depth
  function automatic int unsigned kept_entries();
    if (shadow_count == '0) return 1;
    if (shadow_count > CntW'(Entries)) return Entries;
    return int'(shadow_count);
  endfunction

  function automatic bit outranks(input logic signed [ValW-1:0] a,
                                  input logic signed [ValW-1:0] b);
    return shadow_min_mode ? (a < b) : (a > b);
  endfunction

  function automatic bit roll_idle();
    return !calm && ($urandom_range(0, 99) < 18);
  endfunction

  task automatic list_reseed();
    for (int i = 0; i < Entries; i++) begin
      shadow_val[i] = shadow_min_mode ? CeilSeed : FloorSeed;
      shadow_x[i]   = '0;
      shadow_y[i]   = '0;
    end
  endtask

  // strict beat of the worst entry needed; ties stay below the earlier pixel
  task automatic list_insert(input logic signed [ValW-1:0] v,
                             input logic [PortCoordW-1:0] x,
                             input logic [PortCoordW-1:0] y);
    int unsigned n;
    int unsigned p;
    n = kept_entries();
    p = 0;
    if (!outranks(v, shadow_val[n-1])) return;
    while (p < n - 1 && !outranks(v, shadow_val[p])) p++;
    for (int i = n - 1; i > p; i--) begin
      shadow_val[i] = shadow_val[i-1];
      shadow_x[i]   = shadow_x[i-1];
      shadow_y[i]   = shadow_y[i-1];
    end
    shadow_val[p] = v;
    shadow_x[p]   = x & XyMask;
    shadow_y[p]   = y & XyMask;
  endtask

  // an accepted pixel request: merge it, and on frame end owe the whole list
  task automatic pixel_taken(input logic signed [ValW-1:0] v,
                             input logic [PortCoordW-1:0] x,
                             input logic [PortCoordW-1:0] y,
                             input logic fe);
    ranked_entry_t e;
    int unsigned n;
    list_insert(v, x, y);
    pixels_out++;
    if (!fe) return;
    n = kept_entries();
    for (int k = 0; k < n; k++) begin
      e.rank  = RankW'(k);
      e.x     = shadow_x[k];
      e.y     = shadow_y[k];
      e.value = shadow_val[k];
      e.last  = (k == n - 1);
      readout_q.push_back(e);
    end
    list_reseed();
  endtask

  // any decoded write reseeds the list with the (new) mode's seed
  task automatic reg_taken(input logic [CfgIdxW-1:0] idx,
                           input logic [CfgDataW-1:0] data);
    if (idx == RegModeMin) begin
      shadow_min_mode = data[0];
    end else if (idx == RegCountInUse) begin
      shadow_count = CntW'(data);
    end else begin
      return;
    end
    list_reseed();
  endtask

  // ---------------------------------------------------------------------------
  // drivers
  // ---------------------------------------------------------------------------
  // called at a clock edge; valid stays high afterwards unless the next request
  // or an idle call lowers it
  task automatic send_pixel(input logic signed [ValW-1:0] v,
                            input logic [PortCoordW-1:0] x,
                            input logic [PortCoordW-1:0] y,
                            input logic fe);
    int unsigned gap;
    if (roll_idle()) begin
      gap = $urandom_range(1, 4);
      pix.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    pix.valid       <= 1'b1;
    pix.pixel_value <= v;
    pix.pixel_x     <= x;
    pix.pixel_y     <= y;
    pix.frame_end   <= fe;
    do @(posedge clk_i); while (!pix.ready);
    pixel_taken(v, x, y, fe);
  endtask

  // stop offering pixels and wait for every owed result plus the block latency
  task automatic drain_block();
    pix.valid <= 1'b0;
    wait (readout_q.size() == 0);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // register writes only once the block has gone quiet
  task automatic write_reg(input logic [CfgIdxW-1:0] idx,
                           input logic [CfgDataW-1:0] data);
    drain_block();
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data  <= data;
    do @(posedge clk_i); while (!cfg.ready);
    cfg.valid <= 1'b0;
    reg_taken(idx, data);
  endtask

  // mode write with junk in the undecoded data bits
  task automatic set_mode(input logic min_mode);
    logic [CfgDataW-1:0] d;
    d    = CfgDataW'($urandom);
    d[0] = min_mode;
    write_reg(RegModeMin, d);
  endtask

  // receiver: random idling, or a counted hold-off on request
  always @(posedge clk_i) begin
    if (hold_left != 0) begin
      hold_left--;
      res.ready <= 1'b0;
    end else if (hold_token != hold_seen) begin
      hold_seen = hold_token;
      hold_left = HoldLen;
      res.ready <= 1'b0;
    end else begin
      res.ready <= !roll_idle();
    end
  end

  // ---------------------------------------------------------------------------
  // result check against the oldest owed entry
  // ---------------------------------------------------------------------------
  task automatic check_field(input string name, input logic [ValW-1:0] want,
                             input logic [ValW-1:0] got);
    if (got !== want) begin
      err_cnt++;
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
    end
  endtask

  always @(posedge clk_i) begin : result_check
    ranked_entry_t want;
    if (rst_ni && res.valid && res.ready) begin
      if (readout_q.size() == 0) begin
        err_cnt++;
        $display("%0t: unexpected result, expected none, actual rank %0d value %h",
                 $time, res.rank, res.out_value);
      end else begin
        want = readout_q.pop_front();
        check_field("rank",  ValW'(want.rank), ValW'(res.rank));
        check_field("out_x", ValW'(want.x),    ValW'(res.out_x));
        check_field("out_y", ValW'(want.y),    ValW'(res.out_y));
        check_field("value", want.value,       res.out_value);
        check_field("last",  ValW'(want.last), ValW'(res.last));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------
  // sample of one of the supported integer formats, with ties and extremes
  function automatic logic signed [ValW-1:0] pick_value();
    logic signed [7:0]  s8;
    logic signed [15:0] s16;
    logic signed [31:0] s32;
    logic signed [ValW-1:0] v;
    s8  = 8'($urandom);
    s16 = 16'($urandom);
    s32 = 32'($urandom);
    case ($urandom_range(0, 7))
      0: v = {25'b0, s8};
      1: v = s8;
      2: v = {17'b0, s16};
      3: v = s16;
      4: v = {1'b0, s32};
      5: v = s32;
      6: v = ValW'($urandom_range(0, 3)) - ValW'(1);  // small pool, many ties
      default: begin
        case ($urandom_range(0, 2))
          0: v = ValTop;
          1: v = ValBottom;
          default: v = '0;
        endcase
      end
    endcase
    return v;
  endfunction

  function automatic logic [CfgDataW-1:0] pick_count();
    case ($urandom_range(0, 9))
      0: return CfgDataW'(0);
      1: return CfgDataW'(1);
      2: return CfgDataW'(Entries + 1);
      3: return CfgDataW'(64);
      4: return '1;
      default: return CfgDataW'($urandom_range(1, Entries));
    endcase
  endfunction

  // raster walk from a random origin; a broken frame carries on into the next
  task automatic run_frame(input int unsigned n_pix, input bit ended);
    logic [PortCoordW-1:0] x0;
    logic [PortCoordW-1:0] y0;
    logic [PortCoordW-1:0] x;
    logic [PortCoordW-1:0] y;
    int unsigned w;
    x0 = PortCoordW'($urandom);
    y0 = PortCoordW'($urandom);
    w  = $urandom_range(1, 6);
    for (int i = 0; i < n_pix; i++) begin
      x = x0 + PortCoordW'(i % w);
      y = y0 + PortCoordW'(i / w);
      if ($urandom_range(0, 9) == 0) begin
        x = PortCoordW'($urandom);   // stray coordinates
        y = PortCoordW'($urandom);
      end
      send_pixel(pick_value(), x, y, ended && (i == n_pix - 1));
    end
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------
  // reset state: max mode, 16 entries, seeds of zero at the origin
  task automatic test_reset_defaults();
    send_pixel(ValTop,    16'hFFFF, 16'h0000, 1'b0);
    send_pixel(ValBottom, 16'h1234, 16'hFFFF, 1'b0);  // negative never beats the seed
    send_pixel('0,        16'h0001, 16'h0001, 1'b0);  // tie with the seed stays out
    send_pixel(33'sd5,    16'h00AA, 16'h0055, 1'b0);
    send_pixel(33'sd5,    16'h5500, 16'hAA00, 1'b0);  // tie ranks below the first 5
    send_pixel(33'sd1,    16'h8000, 16'h7FFF, 1'b1);
  endtask

  // min mode with a single entry; the greatest value ties the seed
  task automatic test_min_single();
    set_mode(1'b1);
    write_reg(RegCountInUse, CfgDataW'(1));
    send_pixel(ValTop,    16'h0F0F, 16'hF0F0, 1'b0);
    send_pixel(33'sd7,    16'h0002, 16'h0003, 1'b0);
    send_pixel(ValBottom, 16'hFFFF, 16'hFFFF, 1'b1);
  endtask

  // count of zero acts as one, counts past the depth act as the depth
  task automatic test_count_limits();
    write_reg(RegCountInUse, CfgDataW'(0));
    send_pixel(33'sd3, 16'h0010, 16'h0020, 1'b0);
    send_pixel(33'sd9, 16'h0030, 16'h0040, 1'b1);
    set_mode(1'b0);
    write_reg(RegCountInUse, '1);
    send_pixel(33'sd42, 16'h0100, 16'h0200, 1'b0);
    send_pixel(-33'sd1, 16'h0300, 16'h0400, 1'b0);
    send_pixel(33'sd42, 16'h0500, 16'h0600, 1'b1);
  endtask

  // undecoded indexes change nothing; decoded writes reseed mid-frame
  task automatic test_reg_side_effects();
    write_reg(RegCountInUse, CfgDataW'(2));
    send_pixel(33'sd10, 16'h0007, 16'h0008, 1'b0);
    write_reg(RegUnusedLow, '1);
    write_reg(RegUnusedHigh, '0);
    send_pixel(33'sd20, 16'h0009, 16'h000A, 1'b1);
    send_pixel(33'sd30, 16'h000B, 16'h000C, 1'b0);
    set_mode(1'b0);                                // same mode, still reseeds
    send_pixel(33'sd4,  16'h000D, 16'h000E, 1'b1);
  endtask

  // receiver holds off while frames keep coming, so the input stalls
  task automatic test_backpressure();
    write_reg(RegCountInUse, CfgDataW'(Entries));
    hold_token++;
    for (int f = 0; f < 3; f++) run_frame(4, 1'b1);
  endtask

  // mostly complete raster frames, some broken ones, config changes in between
  task automatic test_random_frames();
    int unsigned start;
    int unsigned frame_no;
    start    = pixels_out;
    frame_no = 0;
    while (pixels_out - start < RandPixels) begin
      calm = (frame_no >= 6 && frame_no < 10);      // a stretch with no idling
      if ($urandom_range(0, 3) == 0) begin
        case ($urandom_range(0, 4))
          0:       write_reg(RegUnusedLow, CfgDataW'($urandom));
          1:       set_mode(1'(($urandom)));
          2:       write_reg(RegCountInUse, pick_count());
          default: begin
            set_mode(1'(($urandom)));
            write_reg(RegCountInUse, pick_count());
          end
        endcase
      end
      if ($urandom_range(0, 7) == 0) begin
        run_frame($urandom_range(1, 3), 1'b0);
      end else if ($urandom_range(0, 9) == 0) begin
        run_frame($urandom_range(20, 30), 1'b1);
      end else begin
        run_frame($urandom_range(1, 10), 1'b1);
      end
      frame_no++;
    end
    calm = 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst_ni          = 1'b0;
    pix.valid       = 1'b0;
    pix.pixel_value = '0;
    pix.pixel_x     = '0;
    pix.pixel_y     = '0;
    pix.frame_end   = 1'b0;
    res.ready       = 1'b0;
    cfg.valid       = 1'b0;
    cfg.index       = '0;
    cfg.data        = '0;
    shadow_min_mode = 1'b0;
    shadow_count    = CntW'(16);
    list_reseed();
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_defaults();
    test_min_single();
    test_count_limits();
    test_reg_side_effects();
    test_backpressure();
    test_random_frames();

    drain_block();
    repeat (DrainCycles) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
